FILE: rtl/core/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg: shared types and defaults for the timed event scheduler
// Operation codes, sequencer states, result flags and parameter defaults.
// ----------------------------------------------------------------------------
package tes_pkg;

  // Default configuration
  localparam int unsigned TES_CAPACITY    = 16;
  localparam int unsigned TES_TIME_BITS   = 32;
  localparam int unsigned TES_HANDLE_BITS = 16;

  localparam int unsigned ModeBits = 2;

  // Request codes
  typedef enum logic [ModeBits-1:0] {
    MODE_SCHED = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_POP   = 2'd2
  } tes_mode_e;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_WR   = 5'b00100,
    S_POP  = 5'b01000,
    S_DONE = 5'b10000
  } tes_state_e;

  // Status flags of one result
  typedef struct packed {
    logic event_valid;
    logic store_empty;
    logic dropped;
  } tes_flags_t;

endpackage

FILE: rtl/core/tes_store.sv
// ----------------------------------------------------------------------------
// tes_store: event storage memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tes_store #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 48,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/tes_ctrl.sv
// ----------------------------------------------------------------------------
// tes_ctrl: scheduler sequencer and shared compare unit
// Keeps the tick counter and a sorted ring of events in the store. An insert
// walks from the tail toward the head, moving each later entry up one slot;
// a pop checks the head entry against the tick count.
// ----------------------------------------------------------------------------
module tes_ctrl
  import tes_pkg::*;
#(
  parameter int unsigned CAPACITY    = TES_CAPACITY,
  parameter int unsigned TIME_BITS   = TES_TIME_BITS,
  parameter int unsigned HANDLE_BITS = TES_HANDLE_BITS,
  parameter int unsigned AW          = $clog2(CAPACITY),
  parameter int unsigned MW          = TIME_BITS + HANDLE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request side
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [ModeBits-1:0]    mode_i,
  input  logic [HANDLE_BITS-1:0] event_id_i,
  input  logic [TIME_BITS-1:0]   due_time_i,
  // result side
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output logic [HANDLE_BITS-1:0] popped_id_o,
  output logic [TIME_BITS-1:0]   popped_time_o,
  output logic [TIME_BITS-1:0]   now_tick_o,
  output tes_flags_t             flags_o,
  // store port
  output logic                   mem_we_o,
  output logic [AW-1:0]          mem_waddr_o,
  output logic [MW-1:0]          mem_wdata_o,
  output logic [AW-1:0]          mem_raddr_o,
  input  logic [MW-1:0]          mem_rdata_i
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);
  localparam logic [AW:0]   CapW = (AW+1)'(CAPACITY);
  localparam logic [AW-1:0] LastSlot = AW'(CAPACITY - 1);

  tes_state_e state_q, state_d;
  logic [AW-1:0]          head_q, head_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          pos_q, pos_d;
  logic [TIME_BITS-1:0]   tick_q, tick_d;
  logic [HANDLE_BITS-1:0] id_q, id_d;
  logic [TIME_BITS-1:0]   due_q, due_d;
  logic [HANDLE_BITS-1:0] pop_id_q, pop_id_d;
  logic [TIME_BITS-1:0]   pop_time_q, pop_time_d;
  tes_flags_t             flags_q, flags_d;

  logic [TIME_BITS-1:0]   rd_time;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic [TIME_BITS-1:0]   cmp_ref;
  logic                   rd_later;

  // Physical slot of a ring offset from the head
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                         input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= CapW) begin
      slot = AW'(sum - CapW);
    end else begin
      slot = AW'(sum);
    end
  endfunction

  assign rd_time   = mem_rdata_i[TIME_BITS-1:0];
  assign rd_handle = mem_rdata_i[MW-1:TIME_BITS];

  // Shared compare: stored due time against the tick (pop) or the new due time
  assign cmp_ref  = (state_q == S_POP) ? tick_q : due_q;
  assign rd_later = (rd_time > cmp_ref);

  // Read address: prefetch the entry the next state compares
  always_comb begin
    mem_raddr_o = head_q;
    if (state_q == S_IDLE) begin
      if (mode_i != MODE_POP && count_q != '0) begin
        mem_raddr_o = slot(head_q, AW'(count_q - CW'(1)));
      end
    end else if (state_q == S_CMP && pos_q >= CW'(2)) begin
      mem_raddr_o = slot(head_q, AW'(pos_q - CW'(2)));
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    pos_d       = pos_q;
    tick_d      = tick_q;
    id_d        = id_q;
    due_d       = due_q;
    pop_id_d    = pop_id_q;
    pop_time_d  = pop_time_q;
    flags_d     = flags_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = slot(head_q, AW'(pos_q));
    mem_wdata_o = {id_q, due_q};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          id_d       = event_id_i;
          due_d      = due_time_i;
          pop_id_d   = '0;
          pop_time_d = '0;
          flags_d    = '0;
          case (mode_i)
            MODE_SCHED: begin
              if (count_q == CapC) begin
                flags_d.dropped = 1'b1;
                state_d         = S_DONE;
              end else if (count_q == '0) begin
                pos_d   = '0;
                state_d = S_WR;
              end else begin
                pos_d   = count_q;
                state_d = S_CMP;
              end
            end
            MODE_TICK: begin
              tick_d  = tick_q + TIME_BITS'(1);
              state_d = S_DONE;
            end
            MODE_POP: begin
              state_d = S_POP;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      // entry at pos-1 is on the read port
      S_CMP: begin
        mem_we_o = 1'b1;
        if (rd_later) begin
          mem_wdata_o = mem_rdata_i;
          pos_d       = pos_q - CW'(1);
          if (pos_q == CW'(1)) begin
            state_d = S_WR;
          end
        end else begin
          count_d = count_q + CW'(1);
          state_d = S_DONE;
        end
      end
      // new entry lands at the head slot
      S_WR: begin
        mem_we_o = 1'b1;
        count_d  = count_q + CW'(1);
        state_d  = S_DONE;
      end
      // head entry is on the read port
      S_POP: begin
        if (count_q != '0 && !rd_later) begin
          flags_d.event_valid = 1'b1;
          pop_id_d            = rd_handle;
          pop_time_d          = rd_time;
          head_d              = (head_q == LastSlot) ? '0 : head_q + AW'(1);
          count_d             = count_q - CW'(1);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      pos_q   <= '0;
      tick_q  <= '0;
      flags_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      tick_q  <= tick_d;
      flags_q <= flags_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    due_q      <= due_d;
    pop_id_q   <= pop_id_d;
    pop_time_q <= pop_time_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign res_valid_o   = (state_q == S_DONE);
  assign popped_id_o   = pop_id_q;
  assign popped_time_o = pop_time_q;
  assign now_tick_o    = tick_q;

  always_comb begin
    flags_o             = flags_q;
    flags_o.store_empty = (count_q == '0);
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("entry count above capacity");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == S_CMP || state_q == S_WR))
    else $error("store written outside insert states");

  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && mode_i == MODE_TICK)
      |=> tick_q == $past(tick_q) + TIME_BITS'(1))
    else $error("tick did not advance by one");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && flags_o.dropped) |-> count_q == CapC)
    else $error("drop reported with room in the store");

  a_pop_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && flags_o.event_valid) |-> popped_time_o <= tick_q)
    else $error("popped event not yet due");
`endif

endmodule

FILE: rtl/core/timed_event_scheduler_core.sv
// ----------------------------------------------------------------------------
// timed_event_scheduler_core: tick counter with a bounded timed event store
//
// Requests come in on the in_valid_i/in_ready_o channel: mode 0 schedules
// event_id_i at due_time_i, mode 1 advances the tick by one, mode 2 pops the
// earliest event if it is due. Each request yields exactly one result on
// out_valid_o/out_ready_i with the popped event (if any), the tick count,
// the empty flag and the drop flag for a schedule into a full store.
// Events with equal due times leave in scheduling order.
// The sequencer handles one request at a time; a new transfer is taken once
// the previous result has moved into the output register.
// Steps from accept to result: a tick, a dropped schedule and the unused
// mode 3 go straight to the result; a pop checks the head entry first; a
// schedule moves each stored entry due later than the new one up one slot
// through the store's single write port, then writes the new entry.
// A stalled receiver holds the output register; the core accepts one more
// request and then waits with its result until the register frees.
// Reset clears the tick count and empties the store; no clearing pass.
// ----------------------------------------------------------------------------
module timed_event_scheduler_core
  import tes_pkg::*;
#(
  parameter int unsigned CAPACITY    = TES_CAPACITY,
  parameter int unsigned TIME_BITS   = TES_TIME_BITS,
  parameter int unsigned HANDLE_BITS = TES_HANDLE_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [ModeBits-1:0]    mode_i,
  input  logic [HANDLE_BITS-1:0] event_id_i,
  input  logic [TIME_BITS-1:0]   due_time_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   event_valid_o,
  output logic [HANDLE_BITS-1:0] popped_id_o,
  output logic [TIME_BITS-1:0]   popped_time_o,
  output logic [TIME_BITS-1:0]   now_tick_o,
  output logic                   store_empty_o,
  output logic                   dropped_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned MW = TIME_BITS + HANDLE_BITS;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [MW-1:0]          mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [MW-1:0]          mem_rdata;

  logic                   res_valid;
  logic                   res_ready;
  logic [HANDLE_BITS-1:0] res_id;
  logic [TIME_BITS-1:0]   res_time;
  logic [TIME_BITS-1:0]   res_tick;
  tes_flags_t             res_flags;

  logic                   out_valid_q;
  logic [HANDLE_BITS-1:0] out_id_q;
  logic [TIME_BITS-1:0]   out_time_q;
  logic [TIME_BITS-1:0]   out_tick_q;
  tes_flags_t             out_flags_q;

  tes_ctrl #(
    .CAPACITY    (CAPACITY),
    .TIME_BITS   (TIME_BITS),
    .HANDLE_BITS (HANDLE_BITS),
    .AW          (AW),
    .MW          (MW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .event_id_i    (event_id_i),
    .due_time_i    (due_time_i),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .popped_id_o   (res_id),
    .popped_time_o (res_time),
    .now_tick_o    (res_tick),
    .flags_o       (res_flags),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  tes_store #(
    .Depth (CAPACITY),
    .Width (MW),
    .AddrW (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: loads when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_id_q    <= res_id;
      out_time_q  <= res_time;
      out_tick_q  <= res_tick;
      out_flags_q <= res_flags;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_valid_o = out_flags_q.event_valid;
  assign popped_id_o   = out_id_q;
  assign popped_time_o = out_time_q;
  assign now_tick_o    = out_tick_q;
  assign store_empty_o = out_flags_q.store_empty;
  assign dropped_o     = out_flags_q.dropped;

endmodule
